/* design/spf_pkg.sv */
// Shared constants, action codes and controller/datapath interface types.
package spf_pkg;

    localparam int SPF_MAX_VERTICES = 16;
    localparam int SPF_COORD_BITS   = 10;
    localparam int SUB_SHIFT        = 7;   // sample height step is 1/128 row

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic ld;
        logic mul;
        logic div;
        logic ins;
        logic fin;
        logic pop;
    } spf_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic hit;
        logic past_last;
        logic div_last;
        logic out_last;
    } spf_stat_t;

endpackage

/* design/spf_ram.sv */
// Generic single-clock RAM, one write port, one registered read port.
module spf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* design/spf_ctrl.sv */
// Sequencing state machine: beat intake, edge walk, divide, insert, span output.
module spf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_action,
    output logic              out_valid,
    input  logic              out_ready,
    input  spf_pkg::spf_stat_t stat,
    output spf_pkg::spf_cmd_t  cmd
);
    import spf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LD   = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_INS  = 4'd5;
    localparam logic [3:0] S_NEXT = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign acc       = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (in_action)
                        ACT_CLEAR:  cmd.clear = 1'b1;
                        ACT_APPEND: cmd.append = 1'b1;
                        ACT_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            state_next = stat.cnt_zero ? S_FIN : S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:   state_next = S_LD;
            S_LD:
            begin
                cmd.ld     = 1'b1;
                state_next = stat.hit ? S_MUL : S_NEXT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT: state_next = stat.past_last ? S_FIN : S_RD;
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.pop = 1'b1;
                    if (stat.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/spf_datapath.sv */
// Vertex store, bounds, edge interpolation divider and sorted crossing list.
module spf_datapath #(
    parameter int MAX_VERTICES = spf_pkg::SPF_MAX_VERTICES,
    parameter int COORD_BITS   = spf_pkg::SPF_COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spf_pkg::spf_cmd_t     cmd,
    output spf_pkg::spf_stat_t    stat,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic [COORD_BITS-1:0] in_row,
    output logic [COORD_BITS-1:0] out_start,
    output logic [COORD_BITS-1:0] out_end,
    output logic [COORD_BITS-1:0] out_row,
    output logic                  out_none
);
    import spf_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 2);
    localparam int NW   = CB + SUB_SHIFT;
    localparam int PW   = 2 * CB + SUB_SHIFT;
    localparam int SW   = $clog2(CB);

    // counts and bounds
    logic [CW-1:0] vcount_reg;
    logic [CB-1:0] xmin_reg;
    logic [CB-1:0] xmax_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] nc_reg;
    logic [CW-1:0] pairs_reg;

    // payload
    logic [CB-1:0] row_reg;
    logic [CB-1:0] px_reg, py_reg;
    logic [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [PW-1:0] rem_reg;
    logic [NW-1:0] den_reg;
    logic [CB-1:0] q_reg;
    logic [SW-1:0] step_reg;
    logic          neg_reg;
    logic [CB-1:0] cr_reg [MAX_VERTICES];

    // vertex store
    logic              full;
    logic              wr_en;
    logic [VW-1:0]     raddr;
    logic [2*CB-1:0]   rdata;
    logic [CB-1:0]     cx, cy;

    assign full  = (vcount_reg >= CW'(MAX_VERTICES));
    assign wr_en = cmd.append && !full;
    // closing edge rereads vertex zero
    assign raddr = (idx_reg == vcount_reg) ? '0 : idx_reg[VW-1:0];

    spf_ram #(
        .WIDTH(2 * CB),
        .DEPTH(MAX_VERTICES)
    ) u_vram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(vcount_reg[VW-1:0]),
        .wdata({in_y, in_x}),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign cx = rdata[CB-1:0];
    assign cy = rdata[2*CB-1:CB];

    // edge ordering and row test
    logic          swap;
    logic [CB-1:0] eax, eay, ebx, eby;
    logic          hit;

    assign swap = (cy < py_reg);
    assign eax  = swap ? cx : px_reg;
    assign eay  = swap ? cy : py_reg;
    assign ebx  = swap ? px_reg : cx;
    assign eby  = swap ? py_reg : cy;
    assign hit  = (idx_reg != '0) && (eay <= row_reg) && (row_reg < eby);

    // multiply operands
    logic [CB-1:0] dx;
    logic [CB-1:0] drow;
    logic [CB-1:0] dy;
    logic [NW-1:0] num;
    assign dx   = (bx_reg >= ax_reg) ? bx_reg - ax_reg : ax_reg - bx_reg;
    assign drow = row_reg - ay_reg;
    assign dy   = by_reg - ay_reg;
    assign num  = {drow, {SUB_SHIFT{1'b0}}} | NW'(1);

    // restoring divide, one quotient bit per cycle
    logic [PW-1:0] trial;
    logic          fits;
    assign trial = PW'(den_reg) << step_reg;
    assign fits  = (rem_reg >= trial);

    // crossing and sorted insert
    logic [CB-1:0] xc;
    logic          keep;
    assign xc   = neg_reg ? ax_reg - q_reg : ax_reg + q_reg;
    assign keep = (xc >= xmin_reg) && (xc <= xmax_reg) && (nc_reg < CW'(MAX_VERTICES));

    logic [CB-1:0] cr_ins [MAX_VERTICES];
    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            logic upd;
            logic prev_le;
            upd     = (CW'(j) < nc_reg) ? (cr_reg[j] > xc) : (CW'(j) == nc_reg);
            prev_le = (j == 0) ? 1'b1 : (cr_reg[(j == 0) ? 0 : j - 1] <= xc);
            if (upd)
            begin
                cr_ins[j] = prev_le ? xc : cr_reg[(j == 0) ? 0 : j - 1];
            end
            else
            begin
                cr_ins[j] = cr_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            xmin_reg   <= '1;
            xmax_reg   <= '0;
            idx_reg    <= '0;
            nc_reg     <= '0;
            pairs_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                vcount_reg <= '0;
                xmin_reg   <= '1;
                xmax_reg   <= '0;
            end
            if (wr_en)
            begin
                vcount_reg <= vcount_reg + CW'(1);
                if (in_x < xmin_reg)
                begin
                    xmin_reg <= in_x;
                end
                if (in_x > xmax_reg)
                begin
                    xmax_reg <= in_x;
                end
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
                nc_reg  <= '0;
            end
            if (cmd.ld)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.ins && keep)
            begin
                nc_reg <= nc_reg + CW'(1);
            end
            if (cmd.fin)
            begin
                pairs_reg <= nc_reg >> 1;
            end
            if (cmd.pop && pairs_reg > CW'(1))
            begin
                pairs_reg <= pairs_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            row_reg <= in_row;
        end
        if (cmd.ld)
        begin
            px_reg <= cx;
            py_reg <= cy;
            ax_reg <= eax;
            ay_reg <= eay;
            bx_reg <= ebx;
            by_reg <= eby;
        end
        if (cmd.mul)
        begin
            rem_reg  <= PW'(dx) * PW'(num);
            den_reg  <= {dy, {SUB_SHIFT{1'b0}}};
            neg_reg  <= (bx_reg < ax_reg);
            step_reg <= SW'(CB - 1);
            q_reg    <= '0;
        end
        if (cmd.div)
        begin
            if (fits)
            begin
                rem_reg         <= rem_reg - trial;
                q_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - SW'(1);
        end
        if (cmd.ins && keep)
        begin
            for (int j = 0; j < MAX_VERTICES; j++)
            begin
                cr_reg[j] <= cr_ins[j];
            end
        end
        if (cmd.pop)
        begin
            for (int j = 0; j < MAX_VERTICES - 2; j++)
            begin
                cr_reg[j] <= cr_reg[j + 2];
            end
        end
    end

    assign stat.cnt_zero  = (vcount_reg == '0);
    assign stat.hit       = hit;
    assign stat.past_last = (idx_reg > vcount_reg);
    assign stat.div_last  = (step_reg == '0);
    assign stat.out_last  = (pairs_reg <= CW'(1));

    assign out_none  = (pairs_reg == '0);
    assign out_start = out_none ? '0 : cr_reg[0];
    assign out_end   = out_none ? '0 : cr_reg[1];
    assign out_row   = row_reg;

endmodule

/* design/scanline_polygon_span_fill.sv */
// Top level of the scanline polygon span fill block.
//
//  channel | dir | beat payload
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tuser action; tdata vertex_x, vertex_y, scanline_y
//  m_*     | out | tdata span_start, span_end, row; tuser no_span; tlast
//
// Clear and append beats are accepted in the idle state. A query walks the n stored
// vertices through the single vertex RAM read port, runs the iterative divider for
// each edge that crosses the row, then gives one result beat per span, or one no_span
// beat if there is none. Input is held off from query accept until the last span beat
// is taken; m_tready low simply holds the current beat.
// Reset clears the vertex count and bounds; RAM contents need no clearing.
module scanline_polygon_span_fill #(
    parameter int MAX_VERTICES = spf_pkg::SPF_MAX_VERTICES,
    parameter int COORD_BITS   = spf_pkg::SPF_COORD_BITS,
    localparam int TW = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [TW-1:0] s_tdata,   // vertex_x, vertex_y, scanline_y, zero pad
    input  logic [1:0]    s_tuser,   // action
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [TW-1:0] m_tdata,   // span_start, span_end, row, zero pad
    output logic [0:0]    m_tuser,   // no_span
    output logic          m_tlast    // last_span
);
    import spf_pkg::*;

    localparam int CB = COORD_BITS;

    spf_cmd_t  cmd;
    spf_stat_t stat;

    logic [CB-1:0] span_start, span_end, row;
    logic          no_span;

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_action(s_tuser),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spf_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_x     (s_tdata[CB-1:0]),
        .in_y     (s_tdata[2*CB-1:CB]),
        .in_row   (s_tdata[3*CB-1:2*CB]),
        .out_start(span_start),
        .out_end  (span_end),
        .out_row  (row),
        .out_none (no_span)
    );

    assign m_tdata = TW'({row, span_end, span_start});
    assign m_tuser = no_span;
    // every query ends on its final span beat
    assign m_tlast = stat.out_last;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the scanline polygon span fill block.
`timescale 1ns / 1ps

module testbench;
    import spf_pkg::*;

    localparam int NV = SPF_MAX_VERTICES;
    localparam int CB = SPF_COORD_BITS;
    localparam int TW = ((3 * CB + 7) / 8) * 8;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]    act;
        logic [CB-1:0] vx;
        logic [CB-1:0] vy;
        logic [CB-1:0] row;
    } cmd_t;

    typedef struct packed {
        logic [CB-1:0] x0;
        logic [CB-1:0] x1;
        logic [CB-1:0] row;
        logic          none;
        logic          last;
    } span_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TW-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TW-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;

    scanline_polygon_span_fill dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state: polygon store and x bounds
    logic [CB-1:0] poly_x [NV];
    logic [CB-1:0] poly_y [NV];
    int unsigned   poly_n;
    logic [CB-1:0] xmin, xmax;

    cmd_t  pending_cmds[$];
    span_t expected_spans[$];
    int    errors = 0;
    int    spans_seen = 0;
    int    queries_sent = 0;
    bit    stim_done = 0;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Apply one accepted command to the predictor and queue resulting spans.
    task automatic predict_spans(input cmd_t c);
        logic [CB-1:0] xs[$];
        longint unsigned num, den, q;
        int unsigned xa, ya, xb, yb, k, x;
        span_t s;
        case (c.act)
            ACT_CLEAR:
            begin
                poly_n = 0; xmin = '1; xmax = '0;
            end
            ACT_APPEND:
            begin
                if (poly_n < NV)
                begin
                    poly_x[poly_n] = c.vx; poly_y[poly_n] = c.vy; poly_n++;
                    if (c.vx < xmin) xmin = c.vx;
                    if (c.vx > xmax) xmax = c.vx;
                end
            end
            ACT_QUERY:
            begin
                for (int i = 0; i < poly_n; i++)
                begin
                    k = (i + 1 == poly_n) ? 0 : i + 1;
                    xa = poly_x[i]; ya = poly_y[i]; xb = poly_x[k]; yb = poly_y[k];
                    if (yb < ya)
                    begin
                        x = xa; xa = xb; xb = x;
                        x = ya; ya = yb; yb = x;
                    end
                    if (!(ya <= c.row && c.row < yb)) continue;
                    num = longint'(c.row - ya) * 128 + 1;
                    den = longint'(yb - ya) * 128;
                    if (xb >= xa)
                    begin
                        q = (longint'(xb - xa) * num) / den; x = xa + 32'(q);
                    end
                    else
                    begin
                        q = (longint'(xa - xb) * num) / den; x = xa - 32'(q);
                    end
                    if (x >= xmin && x <= xmax && xs.size() < NV) xs.push_back(x[CB-1:0]);
                end
                xs.sort();
                if (xs.size() < 2)
                begin
                    s = '{x0: '0, x1: '0, row: c.row, none: 1'b1, last: 1'b1};
                    expected_spans.push_back(s);
                end
                else
                    for (int p = 0; p < xs.size() / 2; p++)
                    begin
                        s = '{x0: xs[2*p], x1: xs[2*p+1], row: c.row, none: 1'b0,
                              last: (p + 1 == xs.size() / 2)};
                        expected_spans.push_back(s);
                    end
            end
            default: ;
        endcase
    endtask

    function automatic cmd_t mk(input logic [1:0] a, input int x, input int y, input int r);
        cmd_t c;
        c.act = a; c.vx = CB'(x); c.vy = CB'(y); c.row = CB'(r);
        return c;
    endfunction

    // Random polygon of 3..NV+2 vertices, mostly small spread, then queries.
    task automatic add_polygon();
        int nvtx, cx, cy, rad, q;
        nvtx = $urandom_range(3, NV + 2);
        rad = ($urandom_range(0, 3) == 0) ? 511 : $urandom_range(4, 120);
        cx = $urandom_range(rad, 1023 - rad);
        cy = $urandom_range(rad, 1023 - rad);
        pending_cmds.push_back(mk(ACT_CLEAR, $urandom, $urandom, $urandom));
        for (int i = 0; i < nvtx; i++)
            pending_cmds.push_back(mk(ACT_APPEND, cx - rad + $urandom_range(0, 2 * rad),
                                      cy - rad + $urandom_range(0, 2 * rad), $urandom));
        q = $urandom_range(2, 6);
        for (int i = 0; i < q; i++)
            pending_cmds.push_back(mk(ACT_QUERY, $urandom, $urandom,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                            : cy - rad + $urandom_range(0, 2 * rad)));
    endtask

    // Driver: bursts with random gaps; valid held until accepted.
    int gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_QUERY) queries_sent++;
                predict_spans(pending_cmds.pop_front());
                if (gap == 0 && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap > 0)
                begin
                    gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_cmds[0].act;
                    s_tdata  <= TW'({pending_cmds[0].row, pending_cmds[0].vy,
                                     pending_cmds[0].vx});
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor with its own stall pattern on m_tready.
    int stall_phase = 0;
    always @(posedge clk)
    begin
        span_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{x0: m_tdata[CB-1:0], x1: m_tdata[2*CB-1:CB],
                        row: m_tdata[3*CB-1:2*CB], none: m_tuser[0], last: m_tlast};
                spans_seen++;
                if (expected_spans.size() == 0)
                    report($sformatf("unexpected span %p", got));
                else
                begin
                    want = expected_spans.pop_front();
                    if (got.x0 != want.x0)
                        report($sformatf("span_start %0d exp %0d", got.x0, want.x0));
                    if (got.x1 != want.x1)
                        report($sformatf("span_end %0d exp %0d", got.x1, want.x1));
                    if (got.row != want.row)
                        report($sformatf("row %0d exp %0d", got.row, want.row));
                    if (got.none != want.none)
                        report($sformatf("no_span %0b exp %0b", got.none, want.none));
                    if (got.last != want.last)
                        report($sformatf("last_span %0b exp %0b", got.last, want.last));
                end
            end
            stall_phase = (stall_phase + 1) % 97;
            if (stall_phase < 30) m_tready <= 1'b1;
            else if (stall_phase < 60) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin
        poly_n = 0; xmin = '1; xmax = '0;
        // directed: short list, extremes, full list, unused code, horizontal edge
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_APPEND, 1023, 1023, 1023));
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 1023));
        pending_cmds.push_back(mk(ACT_APPEND, 0, 0, 0));
        pending_cmds.push_back(mk(ACT_APPEND, 0, 1023, 0));
        pending_cmds.push_back(mk(ACT_QUERY, 1023, 1023, 0));
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 1022));
        pending_cmds.push_back(mk(ACT_UNUSED, 1023, 1023, 500));
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 1023));
        pending_cmds.push_back(mk(ACT_CLEAR, 0, 0, 0));
        for (int i = 0; i < NV + 2; i++)   // overfill with a comb-like shape
            pending_cmds.push_back(mk(ACT_APPEND, i * 60, (i % 2) ? 10 : 900, 0));
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 400));
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 10));
        pending_cmds.push_back(mk(ACT_CLEAR, 1023, 1023, 1023));
        pending_cmds.push_back(mk(ACT_QUERY, 0, 0, 5));
        while (pending_cmds.size() < 320)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_cmds.push_back(mk(2'($urandom_range(0, 3)), $urandom, $urandom,
                                          $urandom));
            else
                add_polygon();
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        $display("covered %0d queries, %0d span beats checked", queries_sent, spans_seen);
        if (errors == 0 && expected_spans.size() == 0)
            $display("** scanline_polygon_span_fill: PASSED **");
        else
            $display("** scanline_polygon_span_fill: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("** scanline_polygon_span_fill: FAILED **");
        $finish;
    end
endmodule
